// ===== design/piaw_pkg.sv =====
// Shared types and constants for the PI controller with anti-windup.
// Used by every module of the block; no dependencies.
package piaw_pkg;

  // Input beat: temperatures in millidegrees C, two's complement.
  typedef struct packed {
    logic signed [23:0] measured_temp;
    logic signed [23:0] target_temp;
  } piaw_in_t;

  // Result beat.
  typedef struct packed {
    logic [16:0] duty;
    logic        integration_held;
    logic        output_clamped;
  } piaw_out_t;

  // Register indexes on the config port.
  typedef enum logic {
    CFG_DUTY_FLOOR   = 1'b0,
    CFG_DUTY_CEILING = 1'b1
  } piaw_cfg_e;

  // Where the controller sum landed.
  typedef enum logic [1:0] {
    ZONE_MID   = 2'b00,
    ZONE_FLOOR = 2'b01,
    ZONE_CEIL  = 2'b10
  } piaw_zone_e;

  // Between the integrator stage and the scaling stage.
  typedef struct packed {
    logic [29:0] scaled;   // 512*s + 7812, valid in ZONE_MID
    piaw_zone_e  zone;
    logic        held;
  } piaw_mid_t;

  localparam int unsigned DUTY_W = 17;

  localparam logic signed [20:0] INTEG_MAX  = 21'sd1000000;
  localparam logic signed [20:0] INTEG_MIN  = -21'sd1000000;
  localparam logic signed [31:0] FULL_SCALE = 32'sd2000000;

  // round(s*2048/62500) = floor((512*s + 7812) / 15625); the division is
  // a multiply by ceil(2^44/15625), exact for dividends below 2^30.
  localparam logic [29:0] ROUND_BIAS  = 30'd7812;
  localparam logic [30:0] RECIP       = 31'd1125899907;
  localparam int unsigned RECIP_SHIFT = 44;

  localparam logic [16:0] FLOOR_RST = 17'd0;
  localparam logic [16:0] CEIL_RST  = 17'd65536;

endpackage

// ===== design/piaw_integ.sv =====
// Integrator stage: error, clamped integral, anti-windup decision, zone.
// Depends on piaw_pkg. Holds the error integral register.
module piaw_integ import piaw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,    // beat moves on to the next stage
  input  piaw_in_t  item_i,
  output piaw_mid_t mid_o
);

  logic signed [20:0] integ_q, integ_d;
  logic signed [24:0] err;
  logic signed [25:0] sum;
  logic signed [20:0] cand;
  logic signed [30:0] err_x;
  logic signed [30:0] prop;
  logic signed [31:0] s_cand, s_prev, s_sel;
  logic               hold;

  assign err = 25'(item_i.target_temp) - 25'(item_i.measured_temp);
  assign sum = 26'(integ_q) + 26'(err);

  always_comb begin
    if (sum > 26'(INTEG_MAX)) begin
      cand = INTEG_MAX;
    end else if (sum < 26'(INTEG_MIN)) begin
      cand = INTEG_MIN;
    end else begin
      cand = sum[20:0];
    end
  end

  // 50*e as shift-adds
  assign err_x  = 31'(err);
  assign prop   = (err_x <<< 5) + (err_x <<< 4) + (err_x <<< 1);
  assign s_cand = 32'(prop) + 32'(cand);
  assign s_prev = 32'(prop) + 32'(integ_q);

  assign hold  = ((s_cand > FULL_SCALE) && (err > 25'sd0)) ||
                 ((s_cand < 32'sd0) && (err < 25'sd0));
  assign s_sel = hold ? s_prev : s_cand;

  always_comb begin
    mid_o.held   = hold;
    mid_o.scaled = {s_sel[20:0], 9'd0} + ROUND_BIAS;
    if (s_sel <= 32'sd0) begin
      mid_o.zone = ZONE_FLOOR;
    end else if (s_sel >= FULL_SCALE) begin
      mid_o.zone = ZONE_CEIL;
    end else begin
      mid_o.zone = ZONE_MID;
    end
  end

  assign integ_d = (adv_i && !hold) ? cand : integ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else begin
      integ_q <= integ_d;
    end
  end

endmodule

// ===== design/piaw_scale.sv =====
// Scaling stage: reciprocal multiply to Q1.16 and floor/ceiling select.
// Depends on piaw_pkg.
module piaw_scale import piaw_pkg::*; (
  input  piaw_mid_t   mid_i,
  input  logic [16:0] floor_i,
  input  logic [16:0] ceil_i,
  output piaw_out_t   res_o
);

  logic [60:0] prod;

  assign prod = 61'(mid_i.scaled) * 61'(RECIP);

  always_comb begin
    res_o.integration_held = mid_i.held;
    case (mid_i.zone)
      ZONE_FLOOR: begin
        res_o.duty           = floor_i;
        res_o.output_clamped = 1'b1;
      end
      ZONE_CEIL: begin
        res_o.duty           = ceil_i;
        res_o.output_clamped = 1'b1;
      end
      default: begin
        res_o.duty           = prod[RECIP_SHIFT +: DUTY_W];
        res_o.output_clamped = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/pi_controller_anti_windup.sv =====
// Top level of the PI temperature controller with anti-windup.
// Depends on piaw_pkg, piaw_integ and piaw_scale.
//
// One input beat is taken every cycle unless the input is stalled, and each
// gives one result beat through three registers (input, integrator and
// output registers). The rate is set by the integral update, which is
// combinational from the input register: error, clamp, proportional sum and
// the hold decision all sit in that path. The divide by 62500 is a single
// 30x31 reciprocal multiply between the integrator register and the output
// register. Stall from the output side backs up through the three stages;
// the block keeps taking beats while any stage is free. The integral is
// cleared by reset only. Floor and ceiling are written on the config port
// (index 0 floor, index 1 ceiling) and should only change while the pipeline is empty.
module pi_controller_anti_windup import piaw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  piaw_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output piaw_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_wdata_i
);

  logic        in_vld_q, mid_vld_q, out_vld_q;
  piaw_in_t    in_q;
  piaw_mid_t   mid_q, mid_d;
  piaw_out_t   out_q, out_d;
  logic [16:0] floor_q, ceil_q;
  logic        accept, adv_mid, adv_out;

  // pipeline flow
  assign adv_out    = mid_vld_q && (!out_vld_q || !out_stall_i);
  assign adv_mid    = in_vld_q && (!mid_vld_q || adv_out);
  assign in_stall_o = in_vld_q && !adv_mid;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (adv_mid) begin
        in_vld_q <= 1'b0;
      end
      if (adv_mid) begin
        mid_vld_q <= 1'b1;
      end else if (adv_out) begin
        mid_vld_q <= 1'b0;
      end
      if (adv_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (adv_mid) begin
      mid_q <= mid_d;
    end
    if (adv_out) begin
      out_q <= out_d;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FLOOR_RST;
      ceil_q  <= CEIL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DUTY_FLOOR:   floor_q <= cfg_wdata_i;
        CFG_DUTY_CEILING: ceil_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // integral advances only when the beat leaves the input register
  piaw_integ u_integ (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv_mid),
    .item_i (in_q),
    .mid_o  (mid_d)
  );

  piaw_scale u_scale (
    .mid_i   (mid_q),
    .floor_i (floor_q),
    .ceil_i  (ceil_q),
    .res_o   (out_d)
  );

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/piaw_checker.sv =====
// Port-level checks for pi_controller_anti_windup, bound to the top level.
// Depends on piaw_pkg.
module piaw_checker import piaw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input piaw_in_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input piaw_out_t   out_data_o
);

  // a stalled input beat stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while stalled");

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // input is only stalled when the pipeline is full up to the output
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // an unclamped duty never exceeds the Q1.16 full scale
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.output_clamped |-> out_data_o.duty <= CEIL_RST)
    else $error("unclamped duty above full scale");

  // with no output stall, an accepted beat passes the input, mid and output registers to the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("result beat missing after pipeline latency");

endmodule

bind pi_controller_anti_windup piaw_checker u_piaw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== verif/tb.sv =====
// Self-checking bench for the PI temperature controller with anti-windup.
// Depends on piaw_pkg and pi_controller_anti_windup; nothing else.
module tb;
  import piaw_pkg::*;

  // Controller arithmetic, kept here in the bench's own terms.
  localparam longint IntegLimit = 1000000;  // +/-100 degC*s in 1e-4 units
  localparam longint PropGain   = 50;
  localparam longint SumFull    = 2000000;  // s at full duty
  localparam longint ScaleMul   = 2048;
  localparam longint ScaleDiv   = 62500;

  localparam int unsigned IdlePct       = 7;     // idle chance per cycle, %
  localparam int unsigned HoldOffCycles = 64;    // long receiver hold-off
  localparam int unsigned DrainCycles   = 8;     // pipe is 3 deep
  localparam int unsigned StallLimit    = 2000;  // cycles with no beat moving
  localparam int unsigned ReportCap     = 100;   // stop printing after this

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  piaw_in_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  piaw_out_t   out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = CFG_DUTY_FLOOR;
  logic [16:0] cfg_wdata_i = '0;

  pi_controller_anti_windup i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow state of the controller.
  longint      integ_acc  = 0;
  logic [16:0] floor_reg  = FLOOR_RST;
  logic [16:0] ceil_reg   = CEIL_RST;

  piaw_in_t    temp_q[$];   // beats waiting to be offered
  piaw_out_t   duty_q[$];   // predicted results, oldest first

  // Shared knobs; calm and hold_req are set by the sequencing block.
  bit          calm       = 1'b0;  // no random idling on either side
  bit          hold_req   = 1'b0;  // ask the receiver for one long hold-off
  bit          hold_done  = 1'b0;
  int unsigned hold_left  = 0;

  logic        in_took    = 1'b0;  // input beat moved at the last rising edge
  int unsigned err_cnt    = 0;
  int unsigned n_in       = 0;
  int unsigned n_out      = 0;
  int unsigned n_held     = 0;
  int unsigned n_clamped  = 0;
  int unsigned quiet_cnt  = 0;

  // One controller step: updates integ_acc and returns the expected result.
  function automatic piaw_out_t predict_duty(piaw_in_t beat);
    longint    err;
    longint    cand;
    longint    sum;
    piaw_out_t res;
    err  = longint'($signed(beat.target_temp)) - longint'($signed(beat.measured_temp));
    cand = integ_acc + err;
    if (cand > IntegLimit) cand = IntegLimit;
    if (cand < -IntegLimit) cand = -IntegLimit;
    sum = PropGain * err + cand;
    res = '0;
    // Conditional integration: keep the old integral when the new one
    // would push further into saturation in the direction of the error.
    if ((sum > SumFull && err > 0) || (sum < 0 && err < 0)) begin
      res.integration_held = 1'b1;
      sum = PropGain * err + integ_acc;
    end else begin
      integ_acc = cand;
    end
    if (sum <= 0) begin
      res.duty           = floor_reg;
      res.output_clamped = 1'b1;
    end else if (sum >= SumFull) begin
      res.duty           = ceil_reg;
      res.output_clamped = 1'b1;
    end else begin
      res.duty = 17'((sum * ScaleMul + ScaleDiv / 2) / ScaleDiv);
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= ReportCap)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Both sides: accept and predict each input beat, and check every result beat.
  always @(posedge clk_i) begin
    piaw_out_t want;
    in_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      duty_q.push_back(predict_duty(in_data_i));
      n_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_out++;
      if (out_data_o.integration_held) n_held++;
      if (out_data_o.output_clamped) n_clamped++;
      if (duty_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= ReportCap)
          $display("%0t: unexpected result beat, expected none, actual duty %0d", $time,
                   out_data_o.duty);
      end else begin
        want = duty_q.pop_front();
        check_field("duty", want.duty, out_data_o.duty);
        check_field("integration_held", 17'(want.integration_held),
                    17'(out_data_o.integration_held));
        check_field("output_clamped", 17'(want.output_clamped),
                    17'(out_data_o.output_clamped));
      end
    end
  end

  // Watchdog: no beat on either side for too long ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cnt = 0;
    else quiet_cnt++;
    if (quiet_cnt >= StallLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, duty_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Sender: a beat is held until taken; a fresh one goes out, or a gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (temp_q.size() > 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        in_data_i  <= temp_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the pipe fills up
  // and in_stall_o has to rise while the sender keeps offering.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldOffCycles;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
    end
  end

  task automatic write_reg(piaw_cfg_e idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_DUTY_FLOOR) floor_reg = val;
    else ceil_reg = val;
  endtask

  task automatic set_limits(logic [16:0] lo, logic [16:0] hi);
    write_reg(CFG_DUTY_FLOOR, lo);
    write_reg(CFG_DUTY_CEILING, hi);
  endtask

  // Wait for an empty pipe: nothing queued, offered or predicted.
  task automatic drain();
    while (temp_q.size() > 0 || in_valid_i || duty_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_beat(longint meas, longint tgt);
    piaw_in_t beat;
    beat.measured_temp = 24'(meas);
    beat.target_temp   = 24'(tgt);
    temp_q.push_back(beat);
  endtask

  function automatic longint pick_edge();
    case ($urandom_range(0, 3))
      0:       return -8388608;
      1:       return 8388607;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Random beats in runs. Most runs keep the error small so the sum stays
  // in the linear range and the integral walks around, up to its clamp on
  // steady ramps; the rest are raw noise and edge values.
  task automatic queue_random(int unsigned count);
    int unsigned left;
    int unsigned run_len;
    int unsigned kind;
    longint      step;
    longint      err;
    longint      tgt;
    left = count;
    while (left > 0) begin
      run_len = $urandom_range(1, 40);
      if (run_len > left) run_len = left;
      kind = $urandom_range(0, 99);
      step = $urandom_range(15000, 20000);
      if ($urandom_range(0, 2) == 0) step = -longint'($urandom_range(1000, 8000));
      for (int unsigned k = 0; k < run_len; k++) begin
        tgt = longint'($urandom_range(0, 16000000)) - 8000000;
        if (kind < 30) begin
          push_beat(tgt - step, tgt);
        end else if (kind < 75) begin
          err = longint'($urandom_range(0, 90000)) - 30000;
          push_beat(tgt - err, tgt);
        end else if (kind < 92) begin
          push_beat(longint'($urandom()), longint'($urandom()));
        end else begin
          push_beat(pick_edge(), pick_edge());
        end
      end
      left -= run_len;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero error, small and large errors, full-range extremes,
    // anti-windup in both directions, floor and ceiling hits.
    set_limits(17'd0, 17'd65536);
    push_beat(0, 0);
    push_beat(0, 1);
    push_beat(0, 10000);
    push_beat(0, 30000);
    push_beat(0, 39000);
    push_beat(0, 8388607);
    push_beat(8388607, -8388608);
    push_beat(-8388608, 8388607);
    push_beat(20000, 0);
    push_beat(8388607, 8388607);
    push_beat(-8388608, -8388608);
    push_beat(-1, 0);
    push_beat(0, -1);
    push_beat(5000, 25000);
    repeat (4) push_beat(0, 20000);
    push_beat(-8388608, 0);
    push_beat(0, -8388608);
    push_beat(1000, 0);
    push_beat(-20000, 0);
    drain();

    // Floor above ceiling: registers are used as written.
    set_limits(17'd65536, 17'd0);
    queue_random(80);
    drain();

    // Random limits, with the long receiver hold-off.
    set_limits(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
    hold_req = 1'b1;
    queue_random(150);
    drain();

    // All-ones floor, and a stretch with no idling at all.
    set_limits(17'h1FFFF, 17'($urandom_range(0, 131071)));
    calm = 1'b1;
    queue_random(100);
    drain();
    calm = 1'b0;

    // Back to reset limits.
    set_limits(FLOOR_RST, CEIL_RST);
    queue_random(150);
    drain();

    $display("Ran %0d beats in, %0d out over 5 limit settings incl. floor > ceiling.",
             n_in, n_out);
    $display("Held integral %0d times, clamped output %0d times, %0d mismatches.",
             n_held, n_clamped, err_cnt);
    if (err_cnt == 0 && duty_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
